// ===== src/tas_pkg.sv =====
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types, register map, mode codes and reciprocal table for the
// target approach smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package tas_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned LIMIT_W = 15;
    localparam int unsigned MODE_W  = 4;
    localparam int unsigned STEPS_W = 4;
    localparam int unsigned RECIP_W = 12;
    localparam int unsigned FRAC_W  = 12;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_STEPS = 2'd2;

    localparam logic [MODE_W-1:0] MODE_DIV2  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_DIV4  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_DIV8  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_CLAMP = 4'd3;
    localparam logic [MODE_W-1:0] MODE_SPEED = 4'd4;
    localparam logic [MODE_W-1:0] MODE_TIME  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_LDIV2 = 4'd6;
    localparam logic [MODE_W-1:0] MODE_LDIV4 = 4'd7;
    localparam logic [MODE_W-1:0] MODE_LDIV8 = 4'd8;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LIMIT_W-1:0] limit;
        logic [STEPS_W-1:0] steps_left;
    } t_cfg;

    // reciprocal of (steps + 1) in Q12, zero entry means snap
    function automatic logic [RECIP_W-1:0] recip(input logic [STEPS_W-1:0] idx);
        logic [RECIP_W-1:0] f;
        case (idx)
            4'd0:    f = 12'h000;
            4'd1:    f = 12'h800;
            4'd2:    f = 12'h555;
            4'd3:    f = 12'h400;
            4'd4:    f = 12'h333;
            4'd5:    f = 12'h2AA;
            4'd6:    f = 12'h249;
            4'd7:    f = 12'h200;
            4'd8:    f = 12'h1C7;
            4'd9:    f = 12'h199;
            4'd10:   f = 12'h174;
            4'd11:   f = 12'h155;
            4'd12:   f = 12'h13B;
            4'd13:   f = 12'h124;
            4'd14:   f = 12'h111;
            default: f = 12'h100;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== src/target_approach_smoother.sv =====
// ----------------------------------------------------------------------------
// target_approach_smoother
// Moves a signed 16-bit value toward a target under a programmable mode.
// ----------------------------------------------------------------------------
// One element per transaction, one result per element. Each element is
// captured in an input register, updated by a single combinational pass
// (one 17x13 multiply in time mode) and held in an output register, so the
// block takes a new transaction every cycle while the output is taken; the
// output register holds while not taken, the input register only when full
// too. The user must write mode, limit and steps_left over APB only while
// no transaction is in flight; the block itself does not enforce this.
`default_nettype none

module target_approach_smoother (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tas_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [tas_pkg::PDATA_W-1:0]        pwdata,
    output logic      [tas_pkg::PDATA_W-1:0]        prdata,
    output logic                                    pready,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [tas_pkg::DATA_W-1:0]  i_current_value,
    input  wire logic signed [tas_pkg::DATA_W-1:0]  i_target_value,
    input  wire logic                               i_last_element,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed      [tas_pkg::DATA_W-1:0]  o_new_value,
    output logic                                    o_last_element_out
);
    import tas_pkg::*;

    t_cfg                      cfg;
    logic                      r_s1_vld;
    logic signed [DATA_W-1:0]  r_s1_cur;
    logic signed [DATA_W-1:0]  r_s1_tgt;
    logic                      r_s1_last;
    logic                      r_out_vld;
    logic signed [DATA_W-1:0]  r_out_val;
    logic                      r_out_last;
    logic signed [DATA_W-1:0]  n_out_val;
    logic                      advance;
    logic                      in_xfer;

    tas_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tas_datapath u_dp (
        .i_cfg (cfg),
        .i_cur (r_s1_cur),
        .i_tgt (r_s1_tgt),
        .o_new (n_out_val)
    );

    assign advance    = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_s1_vld || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cur  <= i_current_value;
            r_s1_tgt  <= i_target_value;
            r_s1_last <= i_last_element;
        end
        if (advance && r_s1_vld) begin
            r_out_val  <= n_out_val;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_new_value        = r_out_val;
    assign o_last_element_out = r_out_last;

endmodule

`default_nettype wire

// ===== src/tas_regs.sv =====
// ----------------------------------------------------------------------------
// tas_regs
// APB register file holding mode, limit and steps_left.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tas_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tas_pkg::PDATA_W-1:0] pwdata,
    output logic      [tas_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output tas_pkg::t_cfg                    o_cfg
);
    import tas_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_MODE:  n_cfg.mode       = pwdata[MODE_W-1:0];
                REG_LIMIT: n_cfg.limit      = pwdata[LIMIT_W-1:0];
                REG_STEPS: n_cfg.steps_left = pwdata[STEPS_W-1:0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:  prdata = {{(PDATA_W-MODE_W){1'b0}}, r_cfg.mode};
            REG_LIMIT: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, r_cfg.limit};
            REG_STEPS: prdata = {{(PDATA_W-STEPS_W){1'b0}}, r_cfg.steps_left};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/tas_datapath.sv =====
// ----------------------------------------------------------------------------
// tas_datapath
// Single-pass update of one element under the selected mode.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_datapath (
    input  wire tas_pkg::t_cfg                      i_cfg,
    input  wire logic signed [tas_pkg::DATA_W-1:0]  i_cur,
    input  wire logic signed [tas_pkg::DATA_W-1:0]  i_tgt,
    output logic signed      [tas_pkg::DATA_W-1:0]  o_new
);
    import tas_pkg::*;

    localparam int unsigned DW = DATA_W + 1;
    localparam int unsigned WW = DATA_W + 2;
    localparam int unsigned PW = DW + RECIP_W + 1;

    logic signed [DW-1:0]      diff;
    logic signed [DW-1:0]      q2, q4, q8, q;
    logic signed [PW-1:0]      prod;
    logic signed [PW-1:0]      prod_b;
    logic signed [DW-1:0]      qt;
    logic [RECIP_W-1:0]        f;
    logic signed [WW-1:0]      c_w, t_w, lim_w, q_w;
    logic signed [WW-1:0]      t_lo, t_hi, c_up, c_dn;
    logic signed [DATA_W-1:0]  step_sum;

    always_comb begin
        diff = DW'(i_tgt) - DW'(i_cur);
        q2   = (diff + $signed({{(DW-1){1'b0}}, diff[DW-1]})) >>> 1;
        q4   = (diff + $signed({{(DW-2){1'b0}}, {2{diff[DW-1]}}})) >>> 2;
        q8   = (diff + $signed({{(DW-3){1'b0}}, {3{diff[DW-1]}}})) >>> 3;

        case (i_cfg.mode)
            MODE_DIV2, MODE_LDIV2: q = q2;
            MODE_DIV4, MODE_LDIV4: q = q4;
            default:               q = q8;
        endcase

        f      = recip(i_cfg.steps_left);
        prod   = PW'(diff) * $signed({1'b0, f});
        prod_b = prod + (prod[PW-1] ? PW'((1 << FRAC_W) - 1) : PW'(0));
        qt     = DW'(prod_b >>> FRAC_W);

        c_w   = WW'(i_cur);
        t_w   = WW'(i_tgt);
        lim_w = $signed({{(WW-LIMIT_W){1'b0}}, i_cfg.limit});
        q_w   = WW'(q);
        t_lo  = t_w - lim_w;
        t_hi  = t_w + lim_w;
        c_up  = c_w + lim_w;
        c_dn  = c_w - lim_w;

        step_sum = i_cur + q[DATA_W-1:0];

        case (i_cfg.mode)
            MODE_DIV2, MODE_DIV4, MODE_DIV8: begin
                o_new = (q == '0) ? i_tgt : step_sum;
            end
            MODE_LDIV2, MODE_LDIV4, MODE_LDIV8: begin
                o_new = (q_w <= -lim_w || q_w >= lim_w) ? step_sum : i_tgt;
            end
            MODE_CLAMP: begin
                if (t_lo > c_w) begin
                    o_new = t_lo[DATA_W-1:0];
                end else if (t_hi < c_w) begin
                    o_new = t_hi[DATA_W-1:0];
                end else begin
                    o_new = i_cur;
                end
            end
            MODE_SPEED: begin
                if (c_w < t_w) begin
                    o_new = (t_w <= c_up) ? i_tgt : c_up[DATA_W-1:0];
                end else begin
                    o_new = (t_w >= c_dn) ? i_tgt : c_dn[DATA_W-1:0];
                end
            end
            MODE_TIME: begin
                o_new = (f == '0) ? i_tgt : (i_cur + qt[DATA_W-1:0]);
            end
            default: o_new = i_cur;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/tas_checker.sv =====
// ----------------------------------------------------------------------------
// tas_checker
// Port-level checks for the target approach smoother.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              pready,
    input  wire logic                              i_in_valid,
    input  wire logic                              o_in_ready,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic signed [tas_pkg::DATA_W-1:0] o_new_value,
    input  wire logic                              o_last_element_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_new_value) && $stable(o_last_element_out))
        else $error("output transaction changed while stalled");

    a_rise_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("output transaction without an accepted input");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("pready low during access");

endmodule

bind target_approach_smoother tas_checker u_tas_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .psel               (psel),
    .pready             (pready),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_new_value        (o_new_value),
    .o_last_element_out (o_last_element_out)
);

`default_nettype wire
